>>> rtl/core/fcpq_pkg.sv
`timescale 1ns / 1ps

package fcpq_pkg;

  // contact phase codes
  typedef enum logic [1:0] {
    PH_UNCONFIRMED = 2'd0,
    PH_SWINGING    = 2'd1,
    PH_SLIDING     = 2'd2,
    PH_SUPPORTING  = 2'd3
  } phase_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_SLIP_LIMIT     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NORMAL_LIMIT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_VERTICAL_LIMIT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ENTER_DWELL    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LEAVE_DWELL    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OTHER_DWELL    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TICK_US        = 3'd6;
  localparam int unsigned CfgDataW = 20;

  // field widths
  localparam int unsigned PosW   = 24;
  localparam int unsigned SumW   = 25;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DwellW = 3;
  localparam int unsigned CntW   = 2;
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 112;

  localparam logic [CntW-1:0]   MaxContrib = 2'd2;
  localparam logic [DwellW-1:0] DwellMax   = 3'd7;

  typedef struct packed {
    logic        [15:0] slip_limit;
    logic signed [15:0] normal_limit;
    logic        [14:0] vertical_limit;
    logic        [2:0]  enter_dwell;
    logic        [2:0]  leave_dwell;
    logic        [2:0]  other_dwell;
    logic        [19:0] tick_us;
  } cfg_t;

  typedef struct packed {
    logic               contact;
    logic        [15:0] planar_speed;
    logic signed [15:0] normal_y;
    logic signed [15:0] vertical_velocity;
  } meas_t;

  typedef struct packed {
    phase_e              committed;
    phase_e              candidate;
    logic [DwellW-1:0]   dwell;
    logic [TimeW-1:0]    time_us;
  } foot_state_t;

  typedef logic [2:0][PosW-1:0] pos_t;
  typedef logic [2:0][SumW-1:0] sum_t;

  // contribution from one item to the tick accumulator
  typedef struct packed {
    logic contrib;
    logic supporting;
    logic eot;
  } tick_ctl_t;

endpackage

>>> rtl/core/foot_contact_phase_qualifier_top.sv
`timescale 1ns / 1ps

// Foot contact phase qualifier. Takes one foot measurement word per clock and
// returns one result word per measurement, through the input register and then
// the result register. Per-foot phase state and the tick totals are read and
// rewritten between those registers, so words for the same foot may follow
// back to back at one word per cycle.
// Stalls on the result side hold the pipeline. Configuration writes take
// effect at once and are meant for when no word is in flight.
module foot_contact_phase_qualifier_top #(
  parameter int unsigned FEET = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fcpq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fcpq_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // contact, slip speed, normal_y, vertical_velocity, pos_x, pos_y, pos_z
  input  logic [fcpq_pkg::InDataW-1:0]      s_axis_tdata,
  // foot
  input  logic                              s_axis_tuser,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // phase, phase time, supporting feet, center_x, center_y, center_z
  output logic [fcpq_pkg::OutDataW-1:0]     m_axis_tdata,
  // foot_out
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  fcpq_pkg::cfg_t              cfg_q;
  logic                        in_vld_q, out_vld_q;
  logic [fcpq_pkg::InDataW-1:0] in_data_q;
  logic                        in_foot_q, in_last_q;
  logic [fcpq_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                        out_foot_q, out_last_q;
  logic                        adv, s_acc;
  logic                        foot_ok;
  fcpq_pkg::meas_t             meas;
  fcpq_pkg::pos_t              pos;
  fcpq_pkg::foot_state_t       st_q [FEET];
  fcpq_pkg::foot_state_t       cur_st, nxt_st;
  fcpq_pkg::phase_e            ph_new;
  fcpq_pkg::phase_e            ph_out;
  logic [fcpq_pkg::TimeW-1:0]  time_out;
  fcpq_pkg::tick_ctl_t         tctl;
  logic [fcpq_pkg::CntW-1:0]   count;
  fcpq_pkg::pos_t              centre;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slip_limit     <= 16'd2458;
      cfg_q.normal_limit   <= 16'sd9830;
      cfg_q.vertical_limit <= 15'd1434;
      cfg_q.enter_dwell    <= 3'd2;
      cfg_q.leave_dwell    <= 3'd3;
      cfg_q.other_dwell    <= 3'd2;
      cfg_q.tick_us        <= 20'd16667;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        fcpq_pkg::CFG_SLIP_LIMIT:     cfg_q.slip_limit     <= cfg_data_i[15:0];
        fcpq_pkg::CFG_NORMAL_LIMIT:   cfg_q.normal_limit   <= cfg_data_i[15:0];
        fcpq_pkg::CFG_VERTICAL_LIMIT: cfg_q.vertical_limit <= cfg_data_i[14:0];
        fcpq_pkg::CFG_ENTER_DWELL:    cfg_q.enter_dwell    <= cfg_data_i[2:0];
        fcpq_pkg::CFG_LEAVE_DWELL:    cfg_q.leave_dwell    <= cfg_data_i[2:0];
        fcpq_pkg::CFG_OTHER_DWELL:    cfg_q.other_dwell    <= cfg_data_i[2:0];
        fcpq_pkg::CFG_TICK_US:        cfg_q.tick_us        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_acc) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // input word register
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_data_q <= s_axis_tdata;
      in_foot_q <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
  end

  // unpack the measurement
  always_comb begin
    meas.contact           = in_data_q[0];
    meas.planar_speed      = in_data_q[16:1];
    meas.normal_y          = in_data_q[32:17];
    meas.vertical_velocity = in_data_q[48:33];
    pos[0]                 = in_data_q[72:49];
    pos[1]                 = in_data_q[96:73];
    pos[2]                 = in_data_q[120:97];
    foot_ok                = (FEET > 1) || (in_foot_q == 1'b0);
  end

  // select the state of the addressed foot
  always_comb begin
    cur_st = st_q[0];
    for (int g = 0; g < FEET; g++) begin
      if (in_foot_q == g[0]) begin
        cur_st = st_q[g];
      end
    end
  end

  fcpq_phase u_phase (
    .cfg_i   (cfg_q),
    .meas_i  (meas),
    .st_i    (cur_st),
    .st_o    (nxt_st),
    .phase_o (ph_new)
  );

  // per-foot state registers
  for (genvar g = 0; g < FEET; g++) begin : g_foot
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[g] <= '{committed: fcpq_pkg::PH_UNCONFIRMED,
                     candidate: fcpq_pkg::PH_UNCONFIRMED,
                     dwell: '0, time_us: '0};
      end else if (adv && foot_ok && in_foot_q == 1'(g)) begin
        st_q[g] <= nxt_st;
      end
    end
  end

  // tick totals
  always_comb begin
    ph_out          = foot_ok ? ph_new : fcpq_pkg::PH_UNCONFIRMED;
    time_out        = foot_ok ? nxt_st.time_us : '0;
    tctl.contrib    = foot_ok && (ph_new == fcpq_pkg::PH_SUPPORTING ||
                                  ph_new == fcpq_pkg::PH_SLIDING);
    tctl.supporting = ph_new == fcpq_pkg::PH_SUPPORTING;
    tctl.eot        = in_last_q;
  end

  fcpq_tick u_tick (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .ctl_i    (tctl),
    .pos_i    (pos),
    .count_o  (count),
    .centre_o (centre)
  );

  // result word register
  always_comb begin
    out_data_d = {4'd0, centre[2], centre[1], centre[0], count, time_out, ph_out};
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_foot_q <= in_foot_q;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_foot_q;
  assign m_axis_tlast  = out_last_q;

  // tick totals show only on the closing word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[107:34] == '0))
    else $error("tick totals on a word that does not close the tick");

  // no more than two feet counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[35:34] != 2'd3))
    else $error("support count out of range");

  // a result is produced for every word that left the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> m_axis_tvalid)
    else $error("result word lost");

  // a result is never dropped while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !m_axis_tready) |=> (in_vld_q && out_vld_q))
    else $error("pipeline advanced under stall");

endmodule

>>> rtl/core/fcpq_phase.sv
`timescale 1ns / 1ps

module fcpq_phase (
  input  fcpq_pkg::cfg_t        cfg_i,
  input  fcpq_pkg::meas_t       meas_i,
  input  fcpq_pkg::foot_state_t st_i,
  output fcpq_pkg::foot_state_t st_o,
  output fcpq_pkg::phase_e      phase_o
);

  logic                 [16:0] abs_vv;
  logic                        sliding;
  fcpq_pkg::phase_e            raw;
  logic [fcpq_pkg::DwellW-1:0] need;
  logic [fcpq_pkg::DwellW-1:0] cnt;
  logic [fcpq_pkg::TimeW:0]    tsum;
  fcpq_pkg::foot_state_t       nx;

  // raw classification of this measurement
  always_comb begin
    abs_vv = meas_i.vertical_velocity[15] ?
             (17'd0 - {meas_i.vertical_velocity[15], meas_i.vertical_velocity}) :
             {1'b0, meas_i.vertical_velocity};
    sliding = (meas_i.planar_speed >= cfg_i.slip_limit) ||
              (meas_i.normal_y <= cfg_i.normal_limit) ||
              (abs_vv >= {2'b00, cfg_i.vertical_limit});
    if (!meas_i.contact) begin
      raw = fcpq_pkg::PH_SWINGING;
    end else if (sliding) begin
      raw = fcpq_pkg::PH_SLIDING;
    end else begin
      raw = fcpq_pkg::PH_SUPPORTING;
    end
  end

  // dwell qualification and phase time
  always_comb begin
    nx   = st_i;
    cnt  = st_i.dwell;
    need = cfg_i.other_dwell;
    if (raw == st_i.committed) begin
      nx.dwell     = '0;
      nx.candidate = st_i.committed;
    end else begin
      if (raw != st_i.candidate) begin
        cnt = 3'd1;
      end else if (st_i.dwell < fcpq_pkg::DwellMax) begin
        cnt = st_i.dwell + 3'd1;
      end
      nx.candidate = raw;
      nx.dwell     = cnt;
      if (st_i.committed != fcpq_pkg::PH_SUPPORTING && raw == fcpq_pkg::PH_SUPPORTING) begin
        need = cfg_i.enter_dwell;
      end else if (st_i.committed == fcpq_pkg::PH_SUPPORTING) begin
        need = cfg_i.leave_dwell;
      end
      if (cnt >= need) begin
        nx.committed = raw;
        nx.dwell     = '0;
        nx.time_us   = '0;
      end
    end
    tsum = {1'b0, nx.time_us} + {13'd0, cfg_i.tick_us};
    nx.time_us = tsum[fcpq_pkg::TimeW] ? '1 : tsum[fcpq_pkg::TimeW-1:0];
    st_o    = nx;
    phase_o = nx.committed;
  end

endmodule

>>> rtl/core/fcpq_tick.sv
`timescale 1ns / 1ps

module fcpq_tick (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  fcpq_pkg::tick_ctl_t         ctl_i,
  input  fcpq_pkg::pos_t              pos_i,
  output logic [fcpq_pkg::CntW-1:0]   count_o,
  output fcpq_pkg::pos_t              centre_o
);

  fcpq_pkg::sum_t              sum_q, sum_d, sum_n;
  fcpq_pkg::pos_t              centre_q, centre_d;
  logic [fcpq_pkg::CntW-1:0]   contrib_q, contrib_d, contrib_n;
  logic [fcpq_pkg::CntW-1:0]   supp_q, supp_d, supp_n;
  logic                        add;

  // accumulate contributing feet, close the tick on end of tick
  always_comb begin
    add       = ctl_i.contrib && (contrib_q < fcpq_pkg::MaxContrib);
    sum_n     = sum_q;
    contrib_n = contrib_q;
    supp_n    = supp_q;
    if (add) begin
      for (int a = 0; a < 3; a++) begin
        sum_n[a] = sum_q[a] + {pos_i[a][fcpq_pkg::PosW-1], pos_i[a]};
      end
      contrib_n = contrib_q + 2'd1;
      if (ctl_i.supporting) begin
        supp_n = supp_q + 2'd1;
      end
    end
    centre_d = centre_q;
    if (contrib_n == 2'd1) begin
      for (int a = 0; a < 3; a++) begin
        centre_d[a] = sum_n[a][fcpq_pkg::PosW-1:0];
      end
    end else if (contrib_n >= 2'd2) begin
      // floor of half the sum
      for (int a = 0; a < 3; a++) begin
        centre_d[a] = sum_n[a][fcpq_pkg::SumW-1:1];
      end
    end
    if (ctl_i.eot) begin
      sum_d     = '0;
      contrib_d = '0;
      supp_d    = '0;
      count_o   = supp_n;
      centre_o  = centre_d;
    end else begin
      sum_d     = sum_n;
      contrib_d = contrib_n;
      supp_d    = supp_n;
      centre_d  = centre_q;
      count_o   = '0;
      centre_o  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      centre_q  <= '0;
      contrib_q <= '0;
      supp_q    <= '0;
    end else if (step_i) begin
      sum_q     <= sum_d;
      centre_q  <= centre_d;
      contrib_q <= contrib_d;
      supp_q    <= supp_d;
    end
  end

endmodule

>>> tb/tb_foot_contact_phase_qualifier_top.sv
`timescale 1ns / 1ps

module tb_foot_contact_phase_qualifier_top;

  localparam int StallLimit      = 2000;
  localparam int LongHold        = 300;
  localparam int WordsPerSetting = 130;
  localparam int HoldWords       = 40;

  // one foot measurement as driven on the input stream
  typedef struct packed {
    logic               foot;
    logic               contact;
    logic [15:0]        slip;
    logic signed [15:0] normal_y;
    logic signed [15:0] vert_vel;
    logic [2:0][23:0]   pos;
    logic               eot;
  } meas_word_t;

  // one phase report as seen on the output stream
  typedef struct packed {
    logic               foot;
    fcpq_pkg::phase_e   phase;
    logic [31:0]        time_us;
    logic [1:0]         support;
    logic [2:0][23:0]   centre;
    logic               done;
  } report_t;

  typedef struct packed {
    meas_word_t m;
    logic       typed;
    report_t    rep;
  } stim_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [fcpq_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [fcpq_pkg::CfgDataW-1:0] cfg_data_i;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [fcpq_pkg::InDataW-1:0]  s_axis_tdata;
  logic                          s_axis_tuser;
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [fcpq_pkg::OutDataW-1:0] m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          m_axis_tlast;

  foot_contact_phase_qualifier_top #(
    .FEET(2)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the registers and the block state
  fcpq_pkg::cfg_t     settings_now = '{16'd2458, 16'sd9830, 15'd1434, 3'd2, 3'd3, 3'd2,
                                       20'd16667};
  fcpq_pkg::phase_e   committed [2] = '{fcpq_pkg::PH_UNCONFIRMED, fcpq_pkg::PH_UNCONFIRMED};
  fcpq_pkg::phase_e   candidate [2] = '{fcpq_pkg::PH_UNCONFIRMED, fcpq_pkg::PH_UNCONFIRMED};
  logic [2:0]         dwell [2] = '{3'd0, 3'd0};
  logic [31:0]        phase_clock [2] = '{32'd0, 32'd0};
  logic signed [24:0] pos_sum [3] = '{25'sd0, 25'sd0, 25'sd0};
  logic [1:0]         support_tally = 2'd0;
  logic [1:0]         contrib_tally = 2'd0;
  logic [23:0]        centre_now [3] = '{24'd0, 24'd0, 24'd0};

  report_t expected_reports [$];
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      source_gap_max = 18;
  int      sink_gap_max = 18;
  bit      long_hold_req = 1'b0;

  // classify, qualify through the dwell and fold into the tick totals
  task automatic predict_report(input meas_word_t m, output report_t r);
    fcpq_pkg::phase_e   raw;
    fcpq_pkg::phase_e   cur;
    int                 vv;
    int                 avv;
    int                 need;
    longint             t;
    logic signed [24:0] half;
    cur = committed[m.foot];
    vv  = int'($signed(m.vert_vel));
    avv = (vv < 0) ? -vv : vv;
    if (!m.contact) begin
      raw = fcpq_pkg::PH_SWINGING;
    end else if (m.slip >= settings_now.slip_limit ||
                 int'($signed(m.normal_y)) <= int'($signed(settings_now.normal_limit)) ||
                 avv >= int'(settings_now.vertical_limit)) begin
      raw = fcpq_pkg::PH_SLIDING;
    end else begin
      raw = fcpq_pkg::PH_SUPPORTING;
    end

    if (raw == cur) begin
      dwell[m.foot]     = 3'd0;
      candidate[m.foot] = cur;
    end else begin
      if (raw != candidate[m.foot]) begin
        candidate[m.foot] = raw;
        dwell[m.foot]     = 3'd1;
      end else if (dwell[m.foot] < fcpq_pkg::DwellMax) begin
        dwell[m.foot] = dwell[m.foot] + 3'd1;
      end
      if (cur != fcpq_pkg::PH_SUPPORTING && raw == fcpq_pkg::PH_SUPPORTING) begin
        need = int'(settings_now.enter_dwell);
      end else if (cur == fcpq_pkg::PH_SUPPORTING) begin
        need = int'(settings_now.leave_dwell);
      end else begin
        need = int'(settings_now.other_dwell);
      end
      if (int'(dwell[m.foot]) >= need) begin
        cur                 = raw;
        committed[m.foot]   = raw;
        dwell[m.foot]       = 3'd0;
        phase_clock[m.foot] = 32'd0;
      end
    end

    // phase time saturates at all ones
    t = longint'(phase_clock[m.foot]) + longint'(settings_now.tick_us);
    phase_clock[m.foot] = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];

    // at most two contributors per tick
    if ((cur == fcpq_pkg::PH_SUPPORTING || cur == fcpq_pkg::PH_SLIDING) &&
        contrib_tally < fcpq_pkg::MaxContrib) begin
      for (int i = 0; i < 3; i++) begin
        pos_sum[i] = pos_sum[i] + $signed({m.pos[i][23], m.pos[i]});
      end
      contrib_tally = contrib_tally + 2'd1;
      if (cur == fcpq_pkg::PH_SUPPORTING) support_tally = support_tally + 2'd1;
    end

    r.foot    = m.foot;
    r.phase   = cur;
    r.time_us = phase_clock[m.foot];
    r.support = 2'd0;
    r.centre  = '0;
    r.done    = m.eot;

    // close the tick; with no contributor the old centre stays
    if (m.eot) begin
      for (int i = 0; i < 3; i++) begin
        if (contrib_tally == 2'd1) begin
          centre_now[i] = pos_sum[i][23:0];
        end else if (contrib_tally >= 2'd2) begin
          half          = pos_sum[i] >>> 1;
          centre_now[i] = half[23:0];
        end
        r.centre[i] = centre_now[i];
        pos_sum[i]  = 25'sd0;
      end
      r.support     = support_tally;
      support_tally = 2'd0;
      contrib_tally = 2'd0;
    end
  endtask

  function automatic logic [23:0] draw_position();
    case ($urandom_range(0, 7))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      default: return 24'($urandom);
    endcase
  endfunction

  // measurement aimed at a class under the current limits
  function automatic meas_word_t make_measurement(logic foot, fcpq_pkg::phase_e cls,
                                                  logic eot);
    meas_word_t m;
    int         slip_lim;
    int         norm_lim;
    int         vert_lim;
    int         mag;
    slip_lim   = int'(settings_now.slip_limit);
    norm_lim   = int'($signed(settings_now.normal_limit));
    vert_lim   = int'(settings_now.vertical_limit);
    m.foot     = foot;
    m.eot      = eot;
    m.contact  = 1'b1;
    m.slip     = 16'($urandom);
    m.normal_y = 16'(int'($urandom_range(0, 32768)) - 16384);
    m.vert_vel = 16'($urandom);
    for (int i = 0; i < 3; i++) m.pos[i] = draw_position();
    case (cls)
      fcpq_pkg::PH_SWINGING: m.contact = 1'b0;
      fcpq_pkg::PH_SUPPORTING: begin
        if (slip_lim > 0) begin
          m.slip = ($urandom_range(0, 3) == 0) ? 16'(slip_lim - 1)
                                                : 16'($urandom_range(0, slip_lim - 1));
        end
        if (norm_lim < 16384) begin
          m.normal_y = ($urandom_range(0, 3) == 0) ? 16'(norm_lim + 1)
              : 16'(norm_lim + 1 + int'($urandom_range(0, 16383 - norm_lim)));
        end
        if (vert_lim > 0) begin
          mag = ($urandom_range(0, 3) == 0) ? vert_lim - 1
                                            : int'($urandom_range(0, vert_lim - 1));
          m.vert_vel = 16'($urandom_range(0, 1) ? -mag : mag);
        end
      end
      fcpq_pkg::PH_SLIDING: begin
        case ($urandom_range(0, 2))
          0: m.slip = ($urandom_range(0, 3) == 0) ? 16'(slip_lim)
                 : 16'(slip_lim + int'($urandom_range(0, 65535 - slip_lim)));
          1: m.normal_y = ($urandom_range(0, 3) == 0) ? 16'(norm_lim)
                 : 16'(norm_lim - int'($urandom_range(0, norm_lim + 16384)));
          default: begin
            mag = ($urandom_range(0, 3) == 0) ? vert_lim
                  : vert_lim + int'($urandom_range(0, 32768 - vert_lim));
            m.vert_vel = 16'((mag == 32768 || $urandom_range(0, 1) == 1) ? -mag : mag);
          end
        endcase
      end
      default: m.contact = 1'($urandom);
    endcase
    return m;
  endfunction

  function automatic meas_word_t word(logic foot, logic contact, int slip, int ny, int vv,
                                     int px, int py, int pz, logic eot);
    meas_word_t m;
    m.foot     = foot;
    m.contact  = contact;
    m.slip     = 16'(slip);
    m.normal_y = 16'(ny);
    m.vert_vel = 16'(vv);
    m.pos[0]   = 24'(px);
    m.pos[1]   = 24'(py);
    m.pos[2]   = 24'(pz);
    m.eot      = eot;
    return m;
  endfunction

  // offer one word after a random gap; predict on acceptance
  task automatic send_word(input meas_word_t m, input logic typed, input report_t typed_rep);
    int      gap;
    report_t rep;
    gap = $urandom_range(0, source_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, m.pos[2], m.pos[1], m.pos[0], m.vert_vel, m.normal_y, m.slip,
                      m.contact};
    s_axis_tuser  <= m.foot;
    s_axis_tlast  <= m.eot;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_report(m, rep);
    expected_reports.push_back(typed ? typed_rep : rep);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apply_settings(input fcpq_pkg::cfg_t c);
    logic [fcpq_pkg::CfgIdxW-1:0] regs [7];
    regs = '{fcpq_pkg::CFG_SLIP_LIMIT, fcpq_pkg::CFG_NORMAL_LIMIT,
             fcpq_pkg::CFG_VERTICAL_LIMIT, fcpq_pkg::CFG_ENTER_DWELL,
             fcpq_pkg::CFG_LEAVE_DWELL, fcpq_pkg::CFG_OTHER_DWELL, fcpq_pkg::CFG_TICK_US};
    settings_now = c;
    foreach (regs[i]) begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= regs[i];
      case (regs[i])
        fcpq_pkg::CFG_SLIP_LIMIT:     cfg_data_i <= fcpq_pkg::CfgDataW'(c.slip_limit);
        fcpq_pkg::CFG_NORMAL_LIMIT:   cfg_data_i <= fcpq_pkg::CfgDataW'({c.normal_limit});
        fcpq_pkg::CFG_VERTICAL_LIMIT: cfg_data_i <= fcpq_pkg::CfgDataW'(c.vertical_limit);
        fcpq_pkg::CFG_ENTER_DWELL:    cfg_data_i <= fcpq_pkg::CfgDataW'(c.enter_dwell);
        fcpq_pkg::CFG_LEAVE_DWELL:    cfg_data_i <= fcpq_pkg::CfgDataW'(c.leave_dwell);
        fcpq_pkg::CFG_OTHER_DWELL:    cfg_data_i <= fcpq_pkg::CfgDataW'(c.other_dwell);
        default:                      cfg_data_i <= fcpq_pkg::CfgDataW'(c.tick_us);
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // random ticks: mostly both feet in order, some short, long or stray ticks
  task automatic run_ticks(input int budget);
    int               sent;
    int               kind;
    int               n;
    logic             f;
    fcpq_pkg::phase_e aim [2];
    sent   = 0;
    aim[0] = fcpq_pkg::PH_SUPPORTING;
    aim[1] = fcpq_pkg::PH_SUPPORTING;
    while (sent < budget) begin
      if ($urandom_range(0, 11) == 0) begin
        source_gap_max = $urandom_range(0, 1) ? 18 : 0;
        sink_gap_max   = $urandom_range(0, 1) ? 18 : 0;
      end
      for (int i = 0; i < 2; i++) begin
        if ($urandom_range(0, 3) == 0) aim[i] = fcpq_pkg::phase_e'($urandom_range(1, 3));
      end
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        send_word(make_measurement(1'($urandom), fcpq_pkg::PH_UNCONFIRMED, 1'($urandom)),
                  1'b0, '0);
        sent++;
      end else begin
        n = (kind == 7) ? 1 : (kind == 8) ? 3 : 2;
        for (int k = 0; k < n; k++) begin
          f = (n == 1 || k == 2) ? 1'($urandom) : 1'(k);
          send_word(make_measurement(f, ($urandom_range(0, 7) == 0) ?
                                     fcpq_pkg::phase_e'($urandom_range(1, 3)) : aim[f],
                                     k == n - 1),
                    1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_report(input report_t got);
    report_t want;
    if (expected_reports.size() == 0) begin
      $error("result word with no expectation pending");
      mismatches++;
      return;
    end
    want = expected_reports.pop_front();
    compare_field("foot_out", want.foot, got.foot);
    compare_field("phase", want.phase, got.phase);
    compare_field("phase_duration_us", want.time_us, got.time_us);
    compare_field("supporting_feet", want.support, got.support);
    compare_field("center_x", $signed(want.centre[0]), $signed(got.centre[0]));
    compare_field("center_y", $signed(want.centre[1]), $signed(got.centre[1]));
    compare_field("center_z", $signed(want.centre[2]), $signed(got.centre[2]));
    compare_field("tick_done", want.done, got.done);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int      gap;
    report_t got;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap           = LongHold;
      end else begin
        gap = $urandom_range(0, sink_gap_max);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.phase     = fcpq_pkg::phase_e'(m_axis_tdata[1:0]);
      got.time_us   = m_axis_tdata[33:2];
      got.support   = m_axis_tdata[35:34];
      got.centre[0] = m_axis_tdata[59:36];
      got.centre[1] = m_axis_tdata[83:60];
      got.centre[2] = m_axis_tdata[107:84];
      got.foot      = m_axis_tuser;
      got.done      = m_axis_tlast;
      check_report(got);
    end
  end

  // watchdog on cycles with no word accepted on either side
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // stimulus
  initial begin
    stim_row_t      steps [$];
    fcpq_pkg::cfg_t plan [4];
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    s_axis_tlast  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed ticks at reset settings
    steps.push_back('{word(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                      '{1'b0, fcpq_pkg::PH_UNCONFIRMED, 32'd16667, 2'd0, 72'd0, 1'b0}});
    steps.push_back('{word(1, 0, 65535, -16384, -32768, 8388607, 8388607, 8388607, 1), 1'b1,
                      '{1'b1, fcpq_pkg::PH_UNCONFIRMED, 32'd16667, 2'd0, 72'd0, 1'b1}});
    steps.push_back('{word(0, 0, 65535, 16384, 32767, -8388608, -8388608, -8388608, 0), 1'b1,
                      '{1'b0, fcpq_pkg::PH_SWINGING, 32'd16667, 2'd0, 72'd0, 1'b0}});
    steps.push_back('{word(1, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1,
                      '{1'b1, fcpq_pkg::PH_SWINGING, 32'd16667, 2'd0, 72'd0, 1'b1}});
    // both feet into support, position extremes and rounding of the mean
    steps.push_back('{word(0, 1, 0, 16384, 0, 8388607, 8388607, 8388607, 0), 1'b0, '0});
    steps.push_back('{word(1, 1, 0, 16384, 0, 8388607, 8388607, 8388607, 1), 1'b0, '0});
    steps.push_back('{word(0, 1, 0, 16384, 0, 8388607, 8388607, 8388607, 0), 1'b0, '0});
    steps.push_back('{word(1, 1, 0, 16384, 0, 8388607, 8388607, 8388607, 1), 1'b0, '0});
    steps.push_back('{word(0, 1, 0, 16384, 0, -8388608, -8388608, -8388608, 0), 1'b0, '0});
    steps.push_back('{word(1, 1, 0, 16384, 0, -8388608, -8388608, -8388608, 1), 1'b0, '0});
    steps.push_back('{word(0, 1, 2457, 9831, 1433, 8388607, -1, 1, 0), 1'b0, '0});
    steps.push_back('{word(1, 1, 0, 16384, -1433, -8388608, 0, 2, 1), 1'b0, '0});
    // each slide condition right at its limit, then extremes
    steps.push_back('{word(0, 1, 2458, 16384, 0, 100, 200, 300, 0), 1'b0, '0});
    steps.push_back('{word(1, 1, 0, 9830, 0, -100, -200, -301, 1), 1'b0, '0});
    steps.push_back('{word(0, 1, 0, 16384, -1434, 5, 6, 7, 0), 1'b0, '0});
    steps.push_back('{word(1, 1, 65535, -16384, -32768, 1, 2, 3, 1), 1'b0, '0});
    // extra contributors in one tick are dropped
    steps.push_back('{word(1, 1, 0, 16384, 32767, 9, 9, 9, 0), 1'b0, '0});
    steps.push_back('{word(0, 1, 0, 16384, 0, 11, 12, 13, 0), 1'b0, '0});
    steps.push_back('{word(0, 1, 0, 16384, 0, -11, -12, -13, 1), 1'b0, '0});
    // both feet lift off; a tick with no contributor keeps the centre
    steps.push_back('{word(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steps.push_back('{word(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
    steps.push_back('{word(1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steps.push_back('{word(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
    steps.push_back('{word(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0});
    steps.push_back('{word(1, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0, '0});
    foreach (steps[i]) send_word(steps[i].m, steps[i].typed, steps[i].rep);
    wait_for_results();

    // register settings: short dwells, extremes, zero dwell and zero tick, random
    plan[0] = '{16'd2458, 16'sd9830, 15'd1434, 3'd1, 3'd7, 3'd1, 20'd1};
    plan[1] = '{16'hFFFF, -16'sd16384, 15'h7FFF, 3'd7, 3'd1, 3'd7, 20'd1000000};
    plan[2] = '{16'd0, 16'sd16384, 15'd0, 3'd0, 3'd0, 3'd0, 20'd0};
    plan[3] = '{16'($urandom_range(1, 65535)), 16'(int'($urandom_range(0, 32768)) - 16384),
                15'($urandom_range(1, 32767)), 3'($urandom_range(1, 7)),
                3'($urandom_range(1, 7)), 3'($urandom_range(1, 7)),
                20'($urandom_range(1, 1000000))};
    foreach (plan[p]) begin
      apply_settings(plan[p]);
      if (p == 0) begin
        // sink holds off while the source keeps pushing
        source_gap_max = 0;
        long_hold_req  = 1'b1;
      end
      run_ticks(WordsPerSetting);
      wait_for_results();
    end

    // long phase time on one foot held swinging at a large step
    apply_settings('{16'd2458, 16'sd9830, 15'd1434, 3'd2, 3'd3, 3'd2, 20'd1000000});
    source_gap_max = 0;
    sink_gap_max   = 0;
    repeat (HoldWords) begin
      send_word(make_measurement(1'b0, fcpq_pkg::PH_SWINGING, 1'b1), 1'b0, '0);
    end
    wait_for_results();
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
